### sv/cfd_pkg.sv
// Shared types and constants for the command frame deframer.
// Used by every module of the block but cfd_ram; depends on nothing else.
`timescale 1ns / 1ps

package cfd_pkg;

  // Size of the content store and the longest run of output words.
  localparam int CONTENT_DEPTH = 64;
  localparam int RUN_LIMIT     = 64;
  localparam int RUN_MAX       = (CONTENT_DEPTH < RUN_LIMIT) ? CONTENT_DEPTH : RUN_LIMIT;
  localparam int ADDR_W        = $clog2(CONTENT_DEPTH);
  localparam int IDX_W         = (RUN_MAX > 1) ? $clog2(RUN_MAX) : 1;
  localparam int RUN_CW        = $clog2(RUN_MAX + 1);

  // Smallest legal length byte: id, command and end byte.
  localparam logic [7:0] LEN_MIN = 8'd3;

  // Register reset values.
  localparam logic [7:0] HEADER_FIRST_RST  = 8'hFE;
  localparam logic [7:0] HEADER_SECOND_RST = 8'hFE;
  localparam logic [7:0] END_MARKER_RST    = 8'hFA;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_HEADER_FIRST  = 2'd0;
  localparam logic [1:0] REG_HEADER_SECOND = 2'd1;
  localparam logic [1:0] REG_END_MARKER    = 2'd2;

  // Output word layout, lowest bit first.
  localparam int OUT_DATA_W = 40;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_len;    // capture the length byte, clear the content count
    logic load_id;     // capture the id byte
    logic load_cmd;    // capture the command byte
    logic store_byte;  // count a content byte and store it if there is room
    logic emit_short;  // present the single word of a content-free frame
    logic run_start;   // latch run length and truncation, clear the run index
    logic rd_issue;    // read the store at the run index
    logic load_out;    // move the read data into the output register
    logic idx_inc;     // step the run index
  } cfd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hdr1_match;
    logic hdr2_match;
    logic len_ok;      // incoming length byte is at least three
    logic len_gt3;     // held length announces content
    logic body_done;   // this content byte completes the declared content
    logic end_match;
    logic run_last;    // current run index is the final one
    logic out_free;    // output register can take a word this cycle
  } cfd_sts_t;

endpackage

### sv/command_frame_deframer_core.sv
// Top level of the command frame deframer.
// Depends on cfd_pkg, cfd_ctrl, cfd_datapath and cfd_ram.
`timescale 1ns / 1ps

// The block takes received serial bytes, one word per handshake on the
// s_tvalid/s_tready/s_tdata channel, and looks for frames made of two header
// bytes, a length byte, an id byte, a command byte, length minus three content
// bytes and an end byte. Up to CONTENT_DEPTH content bytes are kept in a RAM.
// When a frame with content closes on the end marker, the block sends one
// output word per stored byte on m_tvalid/m_tready/m_tdata, with m_tlast on the
// final word and m_tuser set when content was cut off. A frame of length three
// is reported as one word when its command byte is taken.
// Input bytes are taken at one per cycle while a frame is being parsed, except
// a command byte held off as told below; the command byte of a content-free
// frame is registered straight into the output register. Once the end byte is
// taken, the input stays stalled while the run drains: each output word is a
// RAM read, then the load into the output register, as the content store has
// a single read port.
// If the receiver stalls, the output word holds and the drain waits; the
// command byte of a frame is also held off until the output register is free.
// Synchronous reset returns the parser to the first header search, empties
// the output register and restores the three match registers to their
// defaults. The user writes registers through cfg_we/cfg_index/cfg_wdata only
// while the block is idle, which it does not enforce; index three is ignored.
module command_frame_deframer_core
  import cfd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [7:0]            cfg_wdata,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] rx_byte
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [7:0] frame_id, [15:8] command, [23:16] content_length,
  // [29:24] byte_index, [37:30] content_byte, [39:38] zero
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tuser,   // [0] truncated
  output logic                  m_tlast    // last word of the frame's run
);

  cfd_cmd_t cmd;
  cfd_sts_t sts;

  // The controller sequences parsing and draining; it never touches data.
  cfd_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // The datapath holds the frame fields, the content store and the output
  // register, and reports byte matches and run progress back.
  cfd_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .rx_byte  (s_tdata),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_data (m_tdata),
    .out_trunc(m_tuser),
    .out_last (m_tlast)
  );

endmodule

### sv/cfd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the content bytes of the deframer.
`timescale 1ns / 1ps

module cfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/cfd_ctrl.sv
// Frame parser and output run sequencer of the deframer.
// Depends on cfd_pkg; drives the datapath through cfd_cmd_t.
`timescale 1ns / 1ps

module cfd_ctrl
  import cfd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  cfd_sts_t sts,
  output cfd_cmd_t cmd
);

  typedef enum logic [8:0] {
    S_HEAD1 = 9'b000000001,
    S_HEAD2 = 9'b000000010,
    S_LEN   = 9'b000000100,
    S_ID    = 9'b000001000,
    S_CMD   = 9'b000010000,
    S_BODY  = 9'b000100000,
    S_END   = 9'b001000000,
    S_READ  = 9'b010000000,
    S_LOAD  = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  // Bytes are taken in every parse state; the command byte waits for room in
  // the output register because a content-free frame reports there.
  always_comb begin
    unique case (state)
      S_READ, S_LOAD: in_ready = 1'b0;
      S_CMD:          in_ready = sts.out_free;
      default:        in_ready = 1'b1;
    endcase
  end

  assign accept = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_HEAD1: begin
        if (accept && sts.hdr1_match) state_next = S_HEAD2;
      end
      S_HEAD2: begin
        if (accept) state_next = sts.hdr2_match ? S_LEN : S_HEAD1;
      end
      S_LEN: begin
        if (accept) begin
          cmd.load_len = 1'b1;
          state_next   = sts.len_ok ? S_ID : S_HEAD1;
        end
      end
      S_ID: begin
        if (accept) begin
          cmd.load_id = 1'b1;
          state_next  = S_CMD;
        end
      end
      S_CMD: begin
        if (accept) begin
          cmd.load_cmd = 1'b1;
          if (sts.len_gt3) begin
            state_next = S_BODY;
          end else begin
            cmd.emit_short = 1'b1;
            state_next     = S_END;
          end
        end
      end
      S_BODY: begin
        if (accept) begin
          cmd.store_byte = 1'b1;
          if (sts.body_done) state_next = S_END;
        end
      end
      S_END: begin
        if (accept) begin
          if (sts.len_gt3 && sts.end_match) begin
            cmd.run_start = 1'b1;
            state_next    = S_READ;
          end else begin
            state_next = S_HEAD1;
          end
        end
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_next   = S_LOAD;
      end
      S_LOAD: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          if (sts.run_last) begin
            state_next = S_HEAD1;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_READ;
          end
        end
      end
      default: begin
        state_next = S_HEAD1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_HEAD1;
    end else begin
      state <= state_next;
    end
  end

endmodule

### sv/cfd_datapath.sv
// Registers, compares, content store and output register of the deframer.
// Depends on cfd_pkg and cfd_ram; controlled by cfd_ctrl.
`timescale 1ns / 1ps

module cfd_datapath
  import cfd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [7:0]            cfg_wdata,
  input  logic [7:0]            rx_byte,
  input  cfd_cmd_t              cmd,
  output cfd_sts_t              sts,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data,
  output logic                  out_trunc,
  output logic                  out_last
);

  logic [7:0]        header_first;
  logic [7:0]        header_second;
  logic [7:0]        end_marker;
  logic [7:0]        declared_length;
  logic [7:0]        held_id;
  logic [7:0]        held_command;
  logic [7:0]        content_count;
  logic [7:0]        content_count_next;
  logic [7:0]        want;
  logic [IDX_W-1:0]  run_idx;
  logic [RUN_CW-1:0] run_cnt;
  logic              run_trunc;
  logic [7:0]        ram_rdata;
  logic              ram_we;

  logic [7:0] o_id;
  logic [7:0] o_cmd;
  logic [7:0] o_len;
  logic [5:0] o_idx;
  logic [7:0] o_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_first  <= HEADER_FIRST_RST;
      header_second <= HEADER_SECOND_RST;
      end_marker    <= END_MARKER_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HEADER_FIRST:  header_first  <= cfg_wdata;
        REG_HEADER_SECOND: header_second <= cfg_wdata;
        REG_END_MARKER:    end_marker    <= cfg_wdata;
        default:           ;
      endcase
    end
  end

  assign want               = declared_length - LEN_MIN;
  assign content_count_next = (content_count != 8'hFF) ? content_count + 8'd1 : content_count;

  assign sts.hdr1_match = (rx_byte == header_first);
  assign sts.hdr2_match = (rx_byte == header_second);
  assign sts.len_ok     = (rx_byte >= LEN_MIN);
  assign sts.len_gt3    = (declared_length > LEN_MIN);
  assign sts.body_done  = (content_count_next >= want);
  assign sts.end_match  = (rx_byte == end_marker);
  assign sts.run_last   = ((RUN_CW'(run_idx) + RUN_CW'(1)) == run_cnt);
  assign sts.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      declared_length <= '0;
      held_id         <= '0;
      held_command    <= '0;
      content_count   <= '0;
      run_idx         <= '0;
      run_cnt         <= '0;
      run_trunc       <= 1'b0;
    end else begin
      if (cmd.load_len) begin
        declared_length <= rx_byte;
        content_count   <= '0;
      end
      if (cmd.load_id) held_id <= rx_byte;
      if (cmd.load_cmd) held_command <= rx_byte;
      if (cmd.store_byte) content_count <= content_count_next;
      if (cmd.run_start) begin
        run_idx   <= '0;
        run_trunc <= (want > 8'(RUN_MAX));
        run_cnt   <= (want > 8'(RUN_MAX)) ? RUN_CW'(RUN_MAX) : want[RUN_CW-1:0];
      end else if (cmd.idx_inc) begin
        run_idx <= run_idx + IDX_W'(1);
      end
    end
  end

  // Bytes past the end of the store are counted but not kept.
  assign ram_we = cmd.store_byte && (content_count < 8'(CONTENT_DEPTH));

  cfd_ram #(
    .WIDTH(8),
    .DEPTH(CONTENT_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(content_count[ADDR_W-1:0]),
    .wdata(rx_byte),
    .re   (cmd.rd_issue),
    .raddr(ADDR_W'(run_idx)),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_short || cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // A content-free frame reports on its command byte, so that byte is taken
  // straight from the input.
  always_ff @(posedge clk) begin
    if (cmd.emit_short) begin
      o_id      <= held_id;
      o_cmd     <= rx_byte;
      o_len     <= want;
      o_idx     <= '0;
      o_byte    <= '0;
      out_trunc <= 1'b0;
      out_last  <= 1'b1;
    end else if (cmd.load_out) begin
      o_id      <= held_id;
      o_cmd     <= held_command;
      o_len     <= want;
      o_idx     <= 6'(run_idx);
      o_byte    <= ram_rdata;
      out_trunc <= run_trunc;
      out_last  <= sts.run_last;
    end
  end

  assign out_data = {2'b00, o_byte, o_idx, o_len, o_cmd, o_id};

endmodule

### sv/cfd_checker.sv
// Port-level checks for the command frame deframer, bound to the top level.
// Depends on cfd_pkg and command_frame_deframer_core.
`timescale 1ns / 1ps

module cfd_checker
  import cfd_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tuser,
  input logic                  m_tlast
);

  // A stalled word stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  // While a run is still draining, no input byte is taken.
  a_drain_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input taken during a run");

  // Truncation is only flagged when the declared content exceeds the run.
  a_trunc_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[23:16] > 8'(RUN_MAX))
    else $error("truncated flag on a short frame");

  // Each word's index lies inside the declared content.
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[23:16] != 8'd0 |-> {2'b00, m_tdata[29:24]} < m_tdata[23:16])
    else $error("byte index beyond content length");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind command_frame_deframer_core cfd_checker u_cfd_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser),
  .m_tlast (m_tlast)
);
